// ===== rtl/vqfl_pkg.sv =====
`timescale 1ns / 1ps

package vqfl_pkg;

  localparam int DESC_PER_QUEUE = 256;
  localparam int QUEUE_COUNT    = 2;
  localparam int MAX_ALLOC      = 16;

  localparam int IDX_W   = $clog2(DESC_PER_QUEUE);
  localparam int Q_W     = $clog2(QUEUE_COUNT);
  localparam int ADDR_W  = Q_W + IDX_W;
  localparam int DEPTH   = QUEUE_COUNT * DESC_PER_QUEUE;
  localparam int TOT_W   = $clog2(DESC_PER_QUEUE + 1);
  localparam int CNT_W   = 5;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_SET_LINK   = 2'd1,
    OP_FREE_CHAIN = 2'd2,
    OP_NOP        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_FREE    = 2'd1,
    STAT_WALK_BOUND = 2'd2
  } status_t;

  typedef struct packed {
    op_t        op;
    logic       queue_id;
    logic [4:0] count;
    logic [7:0] desc_id;
    logic [7:0] link_next;
    logic       link_valid;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] granted_index;
    logic [8:0] free_left;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic             has_next;
    logic [IDX_W-1:0] next;
  } link_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    link_t             wr_data;
  } mem_req_t;

endpackage

// ===== rtl/virtqueue_descriptor_free_list_top.sv =====
`timescale 1ns / 1ps

// Descriptor free list for two virtqueues of 256 descriptors each. All links
// live in one 512-entry memory with a registered read, and after reset the block
// writes the initial links of all 512 entries with in_stall high. Items are
// handled one at a time: a granted alloc does one memory read per popped
// descriptor, and free_chain one memory read per descriptor of the chain, while
// set_link, unknown ops and a rejected alloc read nothing. Results sit in an output
// register, so the next item can be transferred while the last result still waits.

module virtqueue_descriptor_free_list_top
  import vqfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  mem_req_t  mem_req;
  link_t     rd_data;
  logic      buf_ready;
  logic      push;
  out_item_t res;

  vqfl_link_mem u_link_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  vqfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .buf_ready (buf_ready),
    .push      (push),
    .res       (res)
  );

  vqfl_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .buf_ready (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/vqfl_link_mem.sv =====
`timescale 1ns / 1ps

module vqfl_link_mem
  import vqfl_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output link_t    rd_data
);

  link_t mem [DEPTH];
  link_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/vqfl_out_reg.sv =====
`timescale 1ns / 1ps

module vqfl_out_reg
  import vqfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      buf_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;

  assign buf_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/vqfl_ctrl.sv =====
`timescale 1ns / 1ps

module vqfl_ctrl
  import vqfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output mem_req_t  mem_req,
  input  link_t     rd_data,
  input  logic      buf_ready,
  output logic      push,
  output out_item_t res
);

  typedef enum logic [4:0] {
    ST_CLEAR    = 5'b00001,
    ST_IDLE     = 5'b00010,
    ST_DISPATCH = 5'b00100,
    ST_POP      = 5'b01000,
    ST_WALK     = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  in_item_t          item_r, item_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [IDX_W-1:0]  links_r, links_nxt;
  logic [CNT_W-1:0]  popped_r, popped_nxt;
  logic [IDX_W-1:0]  free_head_r [QUEUE_COUNT];
  logic [IDX_W-1:0]  free_head_nxt [QUEUE_COUNT];
  logic              head_valid_r [QUEUE_COUNT];
  logic              head_valid_nxt [QUEUE_COUNT];
  logic [TOT_W-1:0]  free_total_r [QUEUE_COUNT];
  logic [TOT_W-1:0]  free_total_nxt [QUEUE_COUNT];

  logic [Q_W-1:0]    q;
  logic [IDX_W-1:0]  id;
  logic [IDX_W-1:0]  cur_head;
  logic              cur_hv;
  logic [TOT_W-1:0]  cur_total;
  logic [TOT_W-1:0]  pop_total;
  logic [TOT_W:0]    chain_sum;
  logic [TOT_W-1:0]  chain_total;
  logic              alloc_fail;
  logic              pop_last;
  logic [IDX_W-1:0]  clr_j;
  link_t             clr_link;

  assign q         = Q_W'(item_r.queue_id);
  assign id        = item_r.desc_id[IDX_W-1:0];
  assign cur_head  = free_head_r[q];
  assign cur_hv    = head_valid_r[q];
  assign cur_total = free_total_r[q];
  assign pop_total = cur_total - TOT_W'(1);
  assign chain_sum = {1'b0, cur_total} + (TOT_W + 1)'(links_r) + (TOT_W + 1)'(1);
  assign chain_total = (chain_sum > (TOT_W + 1)'(DESC_PER_QUEUE)) ? TOT_W'(DESC_PER_QUEUE)
                                                                  : chain_sum[TOT_W-1:0];
  assign alloc_fail = (item_r.count == '0) || (item_r.count > CNT_W'(MAX_ALLOC)) ||
                      (cur_total < TOT_W'(item_r.count));
  assign pop_last  = (popped_r + CNT_W'(1)) == item_r.count;
  assign clr_j     = clr_r[IDX_W-1:0];
  assign clr_link.has_next = (clr_j != IDX_W'(DESC_PER_QUEUE - 1));
  assign clr_link.next     = (clr_j != IDX_W'(DESC_PER_QUEUE - 1)) ? clr_j + IDX_W'(1) : '0;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    item_nxt       = item_r;
    tail_nxt       = tail_r;
    links_nxt      = links_r;
    popped_nxt     = popped_r;
    free_head_nxt  = free_head_r;
    head_valid_nxt = head_valid_r;
    free_total_nxt = free_total_r;
    mem_req        = '0;
    push           = 1'b0;
    res            = '0;
    res.status     = STAT_OK;
    res.free_left  = cur_total;
    res.last       = 1'b1;

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.addr    = clr_r;
        mem_req.wr_data = clr_link;
        clr_nxt         = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (item_r.op)
          OP_ALLOC: begin
            if (alloc_fail) begin
              if (buf_ready) begin
                push       = 1'b1;
                res.status = STAT_NO_FREE;
                state_nxt  = ST_IDLE;
              end
            end else begin
              mem_req.rd_en = cur_hv;
              mem_req.addr  = {q, cur_head};
              popped_nxt    = '0;
              state_nxt     = ST_POP;
            end
          end
          OP_SET_LINK: begin
            if (buf_ready) begin
              mem_req.wr_en            = 1'b1;
              mem_req.addr             = {q, id};
              mem_req.wr_data.has_next = item_r.link_valid;
              mem_req.wr_data.next     = item_r.link_next[IDX_W-1:0];
              push                     = 1'b1;
              state_nxt                = ST_IDLE;
            end
          end
          OP_FREE_CHAIN: begin
            mem_req.rd_en = 1'b1;
            mem_req.addr  = {q, id};
            tail_nxt      = id;
            links_nxt     = '0;
            state_nxt     = ST_WALK;
          end
          default: begin
            if (buf_ready) begin
              push      = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_POP: begin
        if (buf_ready) begin
          push = 1'b1;
          if (!cur_hv) begin
            free_total_nxt[q] = '0;
            res.status        = STAT_NO_FREE;
            res.free_left     = '0;
            state_nxt         = ST_IDLE;
          end else begin
            free_total_nxt[q] = pop_total;
            if (rd_data.has_next) begin
              free_head_nxt[q] = rd_data.next;
            end else begin
              head_valid_nxt[q] = 1'b0;
            end
            res.granted_index = 8'(cur_head);
            res.free_left     = pop_total;
            res.last          = pop_last;
            popped_nxt        = popped_r + CNT_W'(1);
            if (pop_last) begin
              state_nxt = ST_IDLE;
            end else begin
              mem_req.rd_en = rd_data.has_next;
              mem_req.addr  = {q, rd_data.next};
            end
          end
        end
      end
      ST_WALK: begin
        if (rd_data.has_next) begin
          if (links_r == IDX_W'(DESC_PER_QUEUE - 1)) begin
            if (buf_ready) begin
              push       = 1'b1;
              res.status = STAT_WALK_BOUND;
              state_nxt  = ST_IDLE;
            end
          end else begin
            links_nxt     = links_r + IDX_W'(1);
            tail_nxt      = rd_data.next;
            mem_req.rd_en = 1'b1;
            mem_req.addr  = {q, rd_data.next};
          end
        end else if (buf_ready) begin
          mem_req.wr_en            = cur_hv;
          mem_req.addr             = {q, tail_r};
          mem_req.wr_data.has_next = 1'b1;
          mem_req.wr_data.next     = cur_head;
          free_head_nxt[q]         = id;
          head_valid_nxt[q]        = 1'b1;
          free_total_nxt[q]        = chain_total;
          push                     = 1'b1;
          res.free_left            = chain_total;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        free_head_r[i]  <= '0;
        head_valid_r[i] <= 1'b1;
        free_total_r[i] <= TOT_W'(DESC_PER_QUEUE);
      end
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      free_head_r  <= free_head_nxt;
      head_valid_r <= head_valid_nxt;
      free_total_r <= free_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    tail_r   <= tail_nxt;
    links_r  <= links_nxt;
    popped_r <= popped_nxt;
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> buf_ready)
    else $error("result pushed while the output register is full");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("link memory read and written in the same cycle");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (in_stall && !push))
    else $error("input taken or result given during the clearing pass");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DISPATCH && in_stall))
    else $error("accepted item not dispatched");

  for (genvar g = 0; g < QUEUE_COUNT; g++) begin : g_total_chk
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
      free_total_r[g] <= TOT_W'(DESC_PER_QUEUE))
      else $error("free count above queue size");
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import vqfl_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic [7:0] lk_next [QUEUE_COUNT][DESC_PER_QUEUE];
  bit         lk_has_next [QUEUE_COUNT][DESC_PER_QUEUE];
  logic [7:0] fl_head [QUEUE_COUNT];
  bit         fl_head_ok [QUEUE_COUNT];
  int         fl_count [QUEUE_COUNT];

  stim_row_t dir_rows[$];
  out_item_t expected_results[$];
  out_item_t item_results[$];

  int errors = 0;
  int cycles = 0;
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  virtqueue_descriptor_free_list_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t mk_item(op_t op, int q, int cnt, int desc, int nxt, int lv);
    in_item_t r;
    r.op = op;
    r.queue_id = 1'(q);
    r.count = 5'(cnt);
    r.desc_id = 8'(desc);
    r.link_next = 8'(nxt);
    r.link_valid = 1'(lv);
    return r;
  endfunction

  function automatic out_item_t mk_res(status_t st, int idx, int left, int lst);
    out_item_t r;
    r.status = st;
    r.granted_index = 8'(idx);
    r.free_left = 9'(left);
    r.last = 1'(lst);
    return r;
  endfunction

  task automatic reset_free_lists();
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      for (int j = 0; j < DESC_PER_QUEUE; j++) begin
        lk_next[q][j] = (j + 1 < DESC_PER_QUEUE) ? 8'(j + 1) : 8'd0;
        lk_has_next[q][j] = (j + 1 < DESC_PER_QUEUE);
      end
      fl_head[q] = 8'd0;
      fl_head_ok[q] = 1'b1;
      fl_count[q] = DESC_PER_QUEUE;
    end
  endtask

  task automatic predict_item(input in_item_t it);
    int q;
    int cnt;
    int links;
    int total;
    logic [7:0] tail;
    logic [7:0] d;
    bit bounded;
    item_results.delete();
    q = int'(it.queue_id);
    cnt = int'(it.count);
    case (it.op)
      OP_ALLOC: begin
        if (cnt == 0 || cnt > MAX_ALLOC || fl_count[q] < cnt) begin
          item_results.push_back(mk_res(STAT_NO_FREE, 0, fl_count[q], 1));
        end else begin
          for (int i = 0; i < cnt; i++) begin
            if (!fl_head_ok[q]) begin
              fl_count[q] = 0;
              item_results.push_back(mk_res(STAT_NO_FREE, 0, 0, 1));
              break;
            end
            d = fl_head[q];
            fl_count[q]--;
            if (lk_has_next[q][d]) begin
              fl_head[q] = lk_next[q][d];
            end else begin
              fl_head_ok[q] = 1'b0;
            end
            item_results.push_back(mk_res(STAT_OK, int'(d), fl_count[q],
                                          (i + 1 == cnt) ? 1 : 0));
          end
        end
      end
      OP_SET_LINK: begin
        lk_next[q][it.desc_id] = it.link_next;
        lk_has_next[q][it.desc_id] = it.link_valid;
        item_results.push_back(mk_res(STAT_OK, 0, fl_count[q], 1));
      end
      OP_FREE_CHAIN: begin
        tail = it.desc_id;
        links = 0;
        bounded = 1'b0;
        while (lk_has_next[q][tail]) begin
          if (links >= DESC_PER_QUEUE - 1) begin
            bounded = 1'b1;
            break;
          end
          links++;
          tail = lk_next[q][tail];
        end
        if (bounded) begin
          item_results.push_back(mk_res(STAT_WALK_BOUND, 0, fl_count[q], 1));
        end else begin
          if (fl_head_ok[q]) begin
            lk_next[q][tail] = fl_head[q];
            lk_has_next[q][tail] = 1'b1;
          end
          fl_head[q] = it.desc_id;
          fl_head_ok[q] = 1'b1;
          total = fl_count[q] + links + 1;
          fl_count[q] = (total > DESC_PER_QUEUE) ? DESC_PER_QUEUE : total;
          item_results.push_back(mk_res(STAT_OK, 0, fl_count[q], 1));
        end
      end
      default: begin
        item_results.push_back(mk_res(STAT_OK, 0, fl_count[q], 1));
      end
    endcase
  endtask

  task automatic add_row(input in_item_t it, input bit typed, input out_item_t res);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  task automatic issue(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    predict_item(it);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      foreach (item_results[k]) expected_results.push_back(item_results[k]);
    end
    gap = (no_idle || hold_req) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic run_random();
    int sent;
    int n;
    int q;
    bit broken;
    bit hold_done;
    bit pause_done;
    in_item_t it;
    logic [7:0] chain[$];
    sent = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    while (sent < 108) begin
      if (!hold_done && sent >= 40) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && sent >= 80) begin
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        pause_done = 1'b1;
      end
      no_idle = (sent >= 95 && sent < 115);
      q = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) begin
        it = mk_item(op_t'($urandom_range(0, 3)), q, $urandom_range(0, 31),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
        issue(it, 1'b0, '0);
        sent++;
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        issue(mk_item(OP_ALLOC, q, n, 0, 0, 0), 1'b0, '0);
        sent++;
        chain.delete();
        foreach (item_results[k]) begin
          if (item_results[k].status == STAT_OK) chain.push_back(item_results[k].granted_index);
        end
        broken = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < chain.size(); i++) begin
          if (i + 1 < chain.size()) begin
            issue(mk_item(OP_SET_LINK, q, $urandom_range(0, 31), chain[i], chain[i + 1], 1),
                  1'b0, '0);
            sent++;
          end else if (!broken) begin
            issue(mk_item(OP_SET_LINK, q, $urandom_range(0, 31), chain[i],
                          $urandom_range(0, 255), 0), 1'b0, '0);
            sent++;
          end
        end
        if (chain.size() > 0) begin
          issue(mk_item(OP_FREE_CHAIN, q, $urandom_range(0, 31), chain[0],
                        $urandom_range(0, 255), $urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    reset_free_lists();
    add_row(mk_item(OP_ALLOC, 0, 0, 0, 0, 0), 1'b1, mk_res(STAT_NO_FREE, 0, 256, 1));
    add_row(mk_item(OP_ALLOC, 0, 17, 0, 0, 0), 1'b1, mk_res(STAT_NO_FREE, 0, 256, 1));
    add_row(mk_item(OP_ALLOC, 1, 31, 0, 0, 0), 1'b1, mk_res(STAT_NO_FREE, 0, 256, 1));
    add_row(mk_item(OP_NOP, 1, 31, 255, 255, 1), 1'b1, mk_res(STAT_OK, 0, 256, 1));
    add_row(mk_item(OP_ALLOC, 0, 1, 0, 0, 0), 1'b1, mk_res(STAT_OK, 0, 255, 1));
    add_row(mk_item(OP_ALLOC, 0, 16, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_SET_LINK, 0, 0, 0, 255, 0), 1'b1, mk_res(STAT_OK, 0, 239, 1));
    add_row(mk_item(OP_FREE_CHAIN, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_SET_LINK, 0, 0, 16, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_FREE_CHAIN, 0, 0, 1, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_ALLOC, 1, 16, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_SET_LINK, 1, 0, 16, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_ALLOC, 1, 3, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_ALLOC, 1, 1, 0, 0, 0), 1'b1, mk_res(STAT_NO_FREE, 0, 0, 1));
    add_row(mk_item(OP_FREE_CHAIN, 1, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_SET_LINK, 1, 0, 17, 17, 1), 1'b0, '0);
    add_row(mk_item(OP_FREE_CHAIN, 1, 0, 17, 0, 0), 1'b1, mk_res(STAT_WALK_BOUND, 0, 17, 1));
    add_row(mk_item(OP_SET_LINK, 1, 0, 17, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_FREE_CHAIN, 1, 0, 17, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_FREE_CHAIN, 1, 0, 18, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_FREE_CHAIN, 0, 0, 255, 0, 0), 1'b0, '0);
    add_row(mk_item(OP_SET_LINK, 0, 0, 254, 0, 0), 1'b0, '0);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[r]) issue(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res);
    run_random();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : result_stall
    int k;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        k = no_idle ? 0 : $urandom_range(0, 17);
        if (k > 0) begin
          out_stall <= 1'b1;
          repeat (k) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d index %0d free %0d last %0d",
                 $time, out_data.status, out_data.granted_index, out_data.free_left,
                 out_data.last);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
        end
        if (out_data.granted_index !== want.granted_index) begin
          errors++;
          $display("%0t: granted_index expected %0d actual %0d", $time, want.granted_index,
                   out_data.granted_index);
        end
        if (out_data.free_left !== want.free_left) begin
          errors++;
          $display("%0t: free_left expected %0d actual %0d", $time, want.free_left,
                   out_data.free_left);
        end
        if (out_data.last !== want.last) begin
          errors++;
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/vqfl_pkg.sv
rtl/vqfl_link_mem.sv
rtl/vqfl_out_reg.sv
rtl/vqfl_ctrl.sv
rtl/virtqueue_descriptor_free_list_top.sv
tb/testbench.sv
